### rtl/core/gvf_pkg.sv
// shared types and constants for the garch variance filter
`timescale 1ns / 1ps
`default_nettype none

package gvf_pkg;

  localparam int P_MAX      = 4;
  localparam int Q_MAX      = 4;
  localparam int NUM_TAPS   = P_MAX + Q_MAX;
  localparam int TAP_CNT_W  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int SAMPLE_W   = 32;
  localparam int VAR_W      = 48;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = COEF_W + VAR_W;
  localparam int ACC_W      = PROD_W + $clog2(NUM_TAPS + 1);
  localparam int ORDER_W    = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int HIST_CAP   = 4;
  localparam int SEEN_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_LEVEL       = 3'd0,
    REG_OMEGA            = 3'd1,
    REG_ALPHA_PACK       = 3'd2,
    REG_BETA_PACK        = 3'd3,
    REG_ORDER_P          = 3'd4,
    REG_ORDER_Q          = 3'd5,
    REG_INITIAL_VARIANCE = 3'd6
  } cfg_reg_t;

  // contents of one tap cell
  typedef struct packed {
    logic [VAR_W-1:0]  value;
    logic [COEF_W-1:0] coef;
    logic              used;
    logic              live;
  } tap_t;

  typedef struct packed {
    logic rotate;
    logic push;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic feed;
  } mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/gvf_in_if.sv
// sample channel: valid/ready with one series sample per beat
`timescale 1ns / 1ps
`default_nettype none

interface gvf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gvf_pkg::SAMPLE_W-1:0] sample;
  logic                                start_of_series;

  modport source (output valid, output sample, output start_of_series, input ready);
  modport sink (input valid, input sample, input start_of_series, output ready);
endinterface

`default_nettype wire

### rtl/core/gvf_out_if.sv
// variance channel: valid/ready with one predicted variance per beat
`timescale 1ns / 1ps
`default_nettype none

interface gvf_out_if;
  logic                       valid;
  logic                       ready;
  logic [gvf_pkg::VAR_W-1:0]  next_variance;
  logic                       saturated;

  modport source (output valid, output next_variance, output saturated, input ready);
  modport sink (input valid, input next_variance, input saturated, output ready);
endinterface

`default_nettype wire

### rtl/core/garch_variance_filter.sv
// top level: garch(p,q) conditional variance over a ring of tap cells
// a sample is taken only while idle, then passes the square, load, mac, drain and
// finish states, and none is taken meanwhile; the 8-tap ring rotates once through
// the single shared multiply-accumulate, and the new variance feeds the next sample
// the output register holds a finished result while the next sample is taken
// reset: registers to their defaults, history empty, no result pending
`timescale 1ns / 1ps
`default_nettype none

module garch_variance_filter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  gvf_in_if.sink                              series,
  gvf_out_if.source                           variance,
  input  wire logic                           cfg_write,
  input  wire logic [gvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gvf_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  logic signed [gvf_pkg::SAMPLE_W-1:0] mean_level;
  logic [gvf_pkg::VAR_W-1:0]           omega;
  logic [4*gvf_pkg::COEF_W-1:0]        alpha_pack;
  logic [4*gvf_pkg::COEF_W-1:0]        beta_pack;
  logic [gvf_pkg::ORDER_W-1:0]         order_p;
  logic [gvf_pkg::ORDER_W-1:0]         order_q;
  logic [gvf_pkg::VAR_W-1:0]           initial_variance;

  logic [gvf_pkg::SEEN_W-1:0]          samples_seen;
  logic [gvf_pkg::SAMPLE_W-1:0]        dev_abs;
  logic [2*gvf_pkg::SAMPLE_W-1:0]      dev_sq;
  logic [gvf_pkg::TAP_CNT_W-1:0]       tap_cnt;
  logic                                out_valid;
  logic [gvf_pkg::VAR_W-1:0]           out_variance;
  logic                                out_saturated;

  logic signed [gvf_pkg::SAMPLE_W:0]   dev;
  logic [gvf_pkg::SAMPLE_W:0]          dev_mag;
  logic [2*gvf_pkg::SAMPLE_W-1:0]      dev_sq_rnd;
  logic [gvf_pkg::VAR_W-1:0]           dsq;
  logic [gvf_pkg::ORDER_W-1:0]         p_used;
  logic [gvf_pkg::ORDER_W-1:0]         q_used;
  logic                                finish_go;
  logic [gvf_pkg::VAR_W-1:0]           mac_result;
  logic                                mac_saturated;

  gvf_pkg::tap_t       taps [gvf_pkg::NUM_TAPS];
  gvf_pkg::cell_ctrl_t dev_ctrl;
  gvf_pkg::cell_ctrl_t var_ctrl;
  gvf_pkg::mac_ctrl_t  mac_ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_level       <= '0;
      omega            <= gvf_pkg::VAR_W'(65536);
      alpha_pack       <= '0;
      beta_pack        <= '0;
      order_p          <= '0;
      order_q          <= '0;
      initial_variance <= gvf_pkg::VAR_W'(65536);
    end else if (cfg_write) begin
      case (cfg_index)
        gvf_pkg::REG_MEAN_LEVEL:       mean_level <= cfg_data[gvf_pkg::SAMPLE_W-1:0];
        gvf_pkg::REG_OMEGA:            omega <= cfg_data[gvf_pkg::VAR_W-1:0];
        gvf_pkg::REG_ALPHA_PACK:       alpha_pack <= cfg_data;
        gvf_pkg::REG_BETA_PACK:        beta_pack <= cfg_data;
        gvf_pkg::REG_ORDER_P:          order_p <= cfg_data[gvf_pkg::ORDER_W-1:0];
        gvf_pkg::REG_ORDER_Q:          order_q <= cfg_data[gvf_pkg::ORDER_W-1:0];
        gvf_pkg::REG_INITIAL_VARIANCE: initial_variance <= cfg_data[gvf_pkg::VAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign dev = {series.sample[gvf_pkg::SAMPLE_W-1], series.sample}
               - {mean_level[gvf_pkg::SAMPLE_W-1], mean_level};
  assign dev_mag = dev[gvf_pkg::SAMPLE_W] ? -dev : dev;
  assign dev_sq_rnd = dev_sq + (2*gvf_pkg::SAMPLE_W)'(32768);
  assign dsq = dev_sq_rnd[2*gvf_pkg::SAMPLE_W-1:gvf_pkg::COEF_W];

  assign p_used = (order_p > gvf_pkg::ORDER_W'(gvf_pkg::P_MAX))
                  ? gvf_pkg::ORDER_W'(gvf_pkg::P_MAX) : order_p;
  assign q_used = (order_q > gvf_pkg::ORDER_W'(gvf_pkg::Q_MAX))
                  ? gvf_pkg::ORDER_W'(gvf_pkg::Q_MAX) : order_q;

  assign finish_go = (state == S_FINISH) && (!out_valid || variance.ready);

  assign dev_ctrl = '{rotate: state == S_MAC, push: state == S_LOAD, load: state == S_LOAD};
  assign var_ctrl = '{rotate: state == S_MAC, push: finish_go, load: state == S_LOAD};
  assign mac_ctrl = '{clear: state == S_LOAD, feed: state == S_MAC};

  // squared-deviation cells, newest first
  for (genvar i = 0; i < gvf_pkg::P_MAX; i++) begin : g_dev
    gvf_tap_cell u_cell (
      .clk       (clk),
      .ctrl      (dev_ctrl),
      .rot_in    (taps[(i + 1) % gvf_pkg::NUM_TAPS]),
      .push_in   ((i == 0) ? dsq : taps[(i + gvf_pkg::NUM_TAPS - 1) % gvf_pkg::NUM_TAPS].value),
      .load_coef (alpha_pack[gvf_pkg::COEF_W*i +: gvf_pkg::COEF_W]),
      .load_used (gvf_pkg::ORDER_W'(i) < p_used),
      .load_live (gvf_pkg::SEEN_W'(i) <= samples_seen),
      .tap       (taps[i])
    );
  end

  // variance cells, newest first
  for (genvar j = 0; j < gvf_pkg::Q_MAX; j++) begin : g_var
    gvf_tap_cell u_cell (
      .clk       (clk),
      .ctrl      (var_ctrl),
      .rot_in    (taps[(gvf_pkg::P_MAX + j + 1) % gvf_pkg::NUM_TAPS]),
      .push_in   ((j == 0) ? mac_result : taps[(gvf_pkg::P_MAX + j + gvf_pkg::NUM_TAPS - 1)
                                              % gvf_pkg::NUM_TAPS].value),
      .load_coef (beta_pack[gvf_pkg::COEF_W*j +: gvf_pkg::COEF_W]),
      .load_used (gvf_pkg::ORDER_W'(j) < q_used),
      .load_live (gvf_pkg::SEEN_W'(j) < samples_seen),
      .tap       (taps[gvf_pkg::P_MAX + j])
    );
  end

  // slots not yet filled since the last restart read as the initial variance
  gvf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .omega     (omega),
    .coef      (taps[0].used ? taps[0].coef : '0),
    .term      (taps[0].live ? taps[0].value : initial_variance),
    .result    (mac_result),
    .saturated (mac_saturated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      samples_seen <= '0;
      tap_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (variance.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (series.valid) begin
            dev_abs <= dev_mag[gvf_pkg::SAMPLE_W-1:0];
            if (series.start_of_series) begin
              samples_seen <= '0;
            end
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          dev_sq <= (2*gvf_pkg::SAMPLE_W)'(dev_abs) * (2*gvf_pkg::SAMPLE_W)'(dev_abs);
          state  <= S_LOAD;
        end
        S_LOAD: begin
          tap_cnt <= '0;
          state   <= S_MAC;
        end
        S_MAC: begin
          tap_cnt <= tap_cnt + 1'b1;
          if (tap_cnt == gvf_pkg::TAP_CNT_W'(gvf_pkg::NUM_TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (finish_go) begin
            out_variance  <= mac_result;
            out_saturated <= mac_saturated;
            if (samples_seen < gvf_pkg::SEEN_W'(gvf_pkg::HIST_CAP)) begin
              samples_seen <= samples_seen + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign series.ready           = (state == S_IDLE);
  assign variance.valid         = out_valid;
  assign variance.next_variance = out_variance;
  assign variance.saturated     = out_saturated;

endmodule

`default_nettype wire

### rtl/core/gvf_tap_cell.sv
// one tap cell of the history ring: history value, coefficient and flags
`timescale 1ns / 1ps
`default_nettype none

module gvf_tap_cell (
  input  wire logic                       clk,
  input  wire gvf_pkg::cell_ctrl_t        ctrl,
  input  wire gvf_pkg::tap_t              rot_in,
  input  wire logic [gvf_pkg::VAR_W-1:0]  push_in,
  input  wire logic [gvf_pkg::COEF_W-1:0] load_coef,
  input  wire logic                       load_used,
  input  wire logic                       load_live,
  output gvf_pkg::tap_t                   tap
);

  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      tap <= rot_in;
    end else begin
      if (ctrl.push) begin
        tap.value <= push_in;
      end
      if (ctrl.load) begin
        tap.coef <= load_coef;
        tap.used <= load_used;
        tap.live <= load_live;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/gvf_mac.sv
// shared multiply-accumulate with round half up and 48-bit clipping
`timescale 1ns / 1ps
`default_nettype none

module gvf_mac (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gvf_pkg::mac_ctrl_t         ctrl,
  input  wire logic [gvf_pkg::VAR_W-1:0]  omega,
  input  wire logic [gvf_pkg::COEF_W-1:0] coef,
  input  wire logic [gvf_pkg::VAR_W-1:0]  term,
  output logic [gvf_pkg::VAR_W-1:0]       result,
  output logic                            saturated
);

  logic [gvf_pkg::PROD_W-1:0] prod;
  logic                       prod_valid;
  logic [gvf_pkg::ACC_W-1:0]  acc;
  logic [gvf_pkg::VAR_W:0]    rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.feed;
    end
  end

  always_ff @(posedge clk) begin
    prod <= gvf_pkg::PROD_W'(coef) * gvf_pkg::PROD_W'(term);
    if (ctrl.clear) begin
      acc <= gvf_pkg::ACC_W'({omega, {gvf_pkg::COEF_W{1'b0}}});
    end else if (prod_valid) begin
      acc <= acc + gvf_pkg::ACC_W'(prod);
    end
  end

  // q32.32 sum to q32.16, half up
  assign rounded = {1'b0, acc[gvf_pkg::PROD_W-1:gvf_pkg::COEF_W]}
                   + (gvf_pkg::VAR_W + 1)'(acc[gvf_pkg::COEF_W-1]);
  assign saturated = (|acc[gvf_pkg::ACC_W-1:gvf_pkg::PROD_W]) | rounded[gvf_pkg::VAR_W];
  assign result = saturated ? {gvf_pkg::VAR_W{1'b1}} : rounded[gvf_pkg::VAR_W-1:0];

endmodule

`default_nettype wire
